// ===== rtl/flv_tag_framer_macros.svh =====
// ---------------------------------------------------------------------------
// FLV tag framer assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FLV_TAG_FRAMER_MACROS_SVH
`define FLV_TAG_FRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define FTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define FTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define FTF_ASSERT_IMP(lbl, ante, cons, msg)
`define FTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ftf_pkg.sv =====
// ---------------------------------------------------------------------------
// FLV tag framer package
// Stream layout, tag codes, controller/datapath interface and header table.
// ---------------------------------------------------------------------------
package ftf_pkg;

  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 72;

  // input tdata field positions (lsb)
  localparam int unsigned PWORD_LSB  = 0;
  localparam int unsigned PBYTES_LSB = 64;
  localparam int unsigned FLEN_LSB   = 68;
  localparam int unsigned TS_LSB     = 92;
  localparam int unsigned KEY_LSB    = 124;
  localparam int unsigned RX_LSB     = 125;
  localparam int unsigned RY_LSB     = 141;
  localparam int unsigned RW_LSB     = 157;
  localparam int unsigned RH_LSB     = 173;

  localparam logic [8:0]  FILE_HDR_LEN  = 9'd319;
  localparam logic [4:0]  TH_LEN_AUDIO  = 5'd12;
  localparam logic [4:0]  TH_LEN_VIDEO  = 5'd20;
  localparam logic [23:0] MAX_FRAME_LEN = 24'd16777206;
  localparam logic [23:0] AUDIO_EXTRA   = 24'd1;
  localparam logic [23:0] VIDEO_EXTRA   = 24'd9;
  localparam logic [24:0] TAG_HDR_BYTES = 25'd11;

  localparam logic [7:0] TAG_AUDIO   = 8'h08;
  localparam logic [7:0] TAG_VIDEO   = 8'h09;
  localparam logic [7:0] VID_KEY     = 8'h18;
  localparam logic [7:0] VID_INTER   = 8'h28;
  localparam logic [7:0] AUD_SPEEX   = 8'hbe;
  localparam logic [7:0] AUD_MP3_16K = 8'hfe;
  localparam logic [7:0] AUD_MP3     = 8'h2f;

  localparam logic [1:0] CODEC_MP3_16K = 2'd1;
  localparam logic [1:0] CODEC_MP3     = 2'd2;

  localparam logic MODE_AUDIO = 1'b1;

  typedef enum logic [1:0] {
    SRC_FHDR,
    SRC_THDR,
    SRC_PAY,
    SRC_TSIZE
  } src_e;

  typedef struct packed {
    logic load;
    logic load_hdr;
    logic emit;
    src_e src;
    logic last_run;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic in_nonempty;
    logic held_last;
    logic held_nonempty;
    logic chunk_final;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] lane_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[63-8*i -: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // file header as big-endian 8-byte groups, last group zero padded
  function automatic logic [63:0] fhdr_word(input logic [5:0] idx);
    logic [63:0] w;
    case (idx)
      6'd0:  w = 64'h464c560105000000;
      6'd1:  w = 64'h0900000000120001;
      6'd2:  w = 64'h2300000000000000;
      6'd3:  w = 64'h02000a6f6e4d6574;
      6'd4:  w = 64'h6144617461080000;
      6'd5:  w = 64'h000d000864757261;
      6'd6:  w = 64'h74696f6e00000000;
      6'd7:  w = 64'h0000000000000c61;
      6'd8:  w = 64'h7564696f636f6465;
      6'd9:  w = 64'h6369640040000000;
      6'd10: w = 64'h00000000000d6175;
      6'd11: w = 64'h64696f6461746172;
      6'd12: w = 64'h61746500403bcccc;
      6'd13: w = 64'hcccccccd000f6175;
      6'd14: w = 64'h64696f73616d706c;
      6'd15: w = 64'h65726174650040e5;
      6'd16: w = 64'h888000000000000f;
      6'd17: w = 64'h617564696f73616d;
      6'd18: w = 64'h706c6573697a6500;
      6'd19: w = 64'h4030000000000000;
      6'd20: w = 64'h000673746572656f;
      6'd21: w = 64'h0101000c76696465;
      6'd22: w = 64'h6f636f6465636964;
      6'd23: w = 64'h0040200000000000;
      6'd24: w = 64'h0000057769647468;
      6'd25: w = 64'h0040840000000000;
      6'd26: w = 64'h0000066865696768;
      6'd27: w = 64'h7400407e00000000;
      6'd28: w = 64'h000000096672616d;
      6'd29: w = 64'h6572617465000000;
      6'd30: w = 64'h000000000000000d;
      6'd31: w = 64'h766964656f646174;
      6'd32: w = 64'h6172617465000000;
      6'd33: w = 64'h0000000000000007;
      6'd34: w = 64'h656e636f64657202;
      6'd35: w = 64'h000b4c6176663532;
      6'd36: w = 64'h2e38372e31000866;
      6'd37: w = 64'h696c6573697a6500;
      6'd38: w = 64'h0000000000000000;
      6'd39: w = 64'h0000090000012e00;
      default: w = 64'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ftf_datapath.sv =====
// ---------------------------------------------------------------------------
// FLV tag framer datapath
// Holds the request, builds the tag header, cuts headers into words and
// drives the output register.
// ---------------------------------------------------------------------------
`include "flv_tag_framer_macros.svh"

module ftf_datapath #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_wdata_i,
  input  logic [ftf_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic                               in_mode_i,
  input  logic                               in_last_i,
  input  ftf_pkg::cmd_t                      cmd_i,
  output ftf_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [ftf_pkg::OUT_TDATA_W-1:0]    out_tdata_o,
  output logic                               out_last_o,
  output logic                               out_eot_o
);

  localparam logic [3:0] WbBytes = 4'(WORD_BYTES);
  localparam logic [8:0] WbLen   = 9'(WORD_BYTES);

  logic [1:0]   codec_q;
  logic [63:0]  pword_q;
  logic [3:0]   pbytes_q;
  logic         plast_q;
  logic [159:0] th_q;
  logic [4:0]   th_len_q;
  logic [24:0]  tag_size_q;
  logic [8:0]   pos_q, pos_d;

  logic         out_valid_q;
  logic [63:0]  out_word_q;
  logic [3:0]   out_bytes_q;
  logic         out_last_q;
  logic         out_eot_q;

  logic [3:0]   in_pbytes, pbytes_sat;
  logic [23:0]  flen, flen_sat, dlen;
  logic [31:0]  ts;
  logic [7:0]   codec_byte, vid_byte;
  logic [159:0] th_d;
  logic [8:0]   src_len, rem;
  logic         chunk_final;
  logic [3:0]   chunk;
  logic [127:0] fh_pair, fh_shift;
  logic [159:0] th_shift;
  logic [63:0]  hdr_word;
  logic [63:0]  word_d;
  logic [3:0]   bytes_d;
  logic         out_free;

  assign in_pbytes  = in_tdata_i[ftf_pkg::PBYTES_LSB +: 4];
  assign pbytes_sat = (in_pbytes > WbBytes) ? WbBytes : in_pbytes;
  assign flen       = in_tdata_i[ftf_pkg::FLEN_LSB +: 24];
  assign flen_sat   = (flen > ftf_pkg::MAX_FRAME_LEN) ? ftf_pkg::MAX_FRAME_LEN : flen;
  assign ts         = in_tdata_i[ftf_pkg::TS_LSB +: 32];
  assign dlen       = flen_sat + ((in_mode_i == ftf_pkg::MODE_AUDIO) ?
                                  ftf_pkg::AUDIO_EXTRA : ftf_pkg::VIDEO_EXTRA);

  always_comb begin
    case (codec_q)
      ftf_pkg::CODEC_MP3_16K: codec_byte = ftf_pkg::AUD_MP3_16K;
      ftf_pkg::CODEC_MP3:     codec_byte = ftf_pkg::AUD_MP3;
      default:                codec_byte = ftf_pkg::AUD_SPEEX;
    endcase
  end

  assign vid_byte = in_tdata_i[ftf_pkg::KEY_LSB] ? ftf_pkg::VID_KEY : ftf_pkg::VID_INTER;

  always_comb begin
    if (in_mode_i == ftf_pkg::MODE_AUDIO) begin
      th_d = {ftf_pkg::TAG_AUDIO, dlen, ts[23:0], ts[31:24], 24'h0, codec_byte, 64'h0};
    end else begin
      th_d = {ftf_pkg::TAG_VIDEO, dlen, ts[23:0], ts[31:24], 24'h0, vid_byte,
              in_tdata_i[ftf_pkg::RX_LSB +: 16], in_tdata_i[ftf_pkg::RY_LSB +: 16],
              in_tdata_i[ftf_pkg::RW_LSB +: 16], in_tdata_i[ftf_pkg::RH_LSB +: 16]};
    end
  end

  // header chunk at the current byte position
  assign src_len     = (cmd_i.src == ftf_pkg::SRC_FHDR) ? ftf_pkg::FILE_HDR_LEN
                                                        : {4'b0, th_len_q};
  assign rem         = src_len - pos_q;
  assign chunk_final = (rem <= WbLen);
  assign chunk       = chunk_final ? rem[3:0] : WbBytes;

  assign fh_pair  = {ftf_pkg::fhdr_word(pos_q[8:3]), ftf_pkg::fhdr_word(pos_q[8:3] + 6'd1)};
  assign fh_shift = fh_pair << {pos_q[2:0], 3'b000};
  assign th_shift = th_q << {pos_q[4:0], 3'b000};
  assign hdr_word = ((cmd_i.src == ftf_pkg::SRC_FHDR) ? fh_shift[127:64] : th_shift[159:96])
                    & ftf_pkg::lane_mask(chunk);

  always_comb begin
    pos_d = pos_q;
    case (cmd_i.src)
      ftf_pkg::SRC_FHDR, ftf_pkg::SRC_THDR: begin
        word_d  = hdr_word;
        bytes_d = chunk;
        if (cmd_i.emit) begin
          pos_d = chunk_final ? 9'd0 : pos_q + {5'b0, chunk};
        end
      end
      ftf_pkg::SRC_PAY: begin
        word_d  = pword_q;
        bytes_d = pbytes_q;
      end
      default: begin
        word_d  = {7'b0, tag_size_q, 32'h0};
        bytes_d = 4'd4;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        codec_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pword_q  <= in_tdata_i[ftf_pkg::PWORD_LSB +: 64];
      pbytes_q <= pbytes_sat;
      plast_q  <= in_last_i;
    end
    if (cmd_i.load_hdr) begin
      th_q       <= th_d;
      th_len_q   <= (in_mode_i == ftf_pkg::MODE_AUDIO) ? ftf_pkg::TH_LEN_AUDIO
                                                       : ftf_pkg::TH_LEN_VIDEO;
      tag_size_q <= {1'b0, dlen} + ftf_pkg::TAG_HDR_BYTES;
    end
    if (cmd_i.emit) begin
      out_word_q  <= word_d;
      out_bytes_q <= bytes_d;
      out_last_q  <= cmd_i.last_run;
      out_eot_q   <= (cmd_i.src == ftf_pkg::SRC_TSIZE);
    end
  end

  assign sts_o.in_last       = in_last_i;
  assign sts_o.in_nonempty   = (in_pbytes != 4'd0);
  assign sts_o.held_last     = plast_q;
  assign sts_o.held_nonempty = (pbytes_q != 4'd0);
  assign sts_o.chunk_final   = chunk_final;
  assign sts_o.out_free      = out_free;

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {4'b0, out_bytes_q, out_word_q};
  assign out_last_o  = out_last_q;
  assign out_eot_o   = out_eot_q;

  `FTF_ASSERT_IMP(a_out_bytes_range, out_valid_q, (out_bytes_q != 4'd0) && (out_bytes_q <= WbBytes), "output word with byte count out of range")

endmodule

// ===== rtl/ftf_ctrl.sv =====
// ---------------------------------------------------------------------------
// FLV tag framer controller
// Sequences file header, tag header, payload and previous-tag size words.
// ---------------------------------------------------------------------------
`include "flv_tag_framer_macros.svh"

module ftf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  ftf_pkg::sts_t sts_i,
  output ftf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FHDR,
    ST_THDR,
    ST_PAY,
    ST_TSIZE
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   in_frame_q;
  logic   header_sent_q;
  logic   accept;

  assign accept = s_valid_i && ready_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.src      = ftf_pkg::SRC_PAY;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load     = 1'b1;
          cmd_o.load_hdr = !in_frame_q;
          if (!in_frame_q) begin
            state_d = header_sent_q ? ST_THDR : ST_FHDR;
          end else if (sts_i.in_nonempty) begin
            state_d = ST_PAY;
          end else if (sts_i.in_last) begin
            state_d = ST_TSIZE;
          end
        end
      end
      ST_FHDR: begin
        cmd_o.src = ftf_pkg::SRC_FHDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.chunk_final) begin
            state_d = ST_THDR;
          end
        end
      end
      ST_THDR: begin
        cmd_o.src = ftf_pkg::SRC_THDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.chunk_final) begin
            cmd_o.last_run = !sts_i.held_nonempty && !sts_i.held_last;
            if (sts_i.held_nonempty) begin
              state_d = ST_PAY;
            end else if (sts_i.held_last) begin
              state_d = ST_TSIZE;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_PAY: begin
        cmd_o.src = ftf_pkg::SRC_PAY;
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last_run = !sts_i.held_last;
          state_d        = sts_i.held_last ? ST_TSIZE : ST_IDLE;
        end
      end
      ST_TSIZE: begin
        cmd_o.src = ftf_pkg::SRC_TSIZE;
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last_run = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ready_q       <= 1'b1;
      in_frame_q    <= 1'b0;
      header_sent_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
      if (accept) begin
        in_frame_q <= !sts_i.in_last;
        if (!in_frame_q) begin
          header_sent_q <= 1'b1;
        end
      end
    end
  end

  assign s_ready_o = ready_q;

  `FTF_ASSERT_IMP(a_ready_in_idle, ready_q, state_q == ST_IDLE, "ready raised outside idle")
  `FTF_ASSERT_IMP(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "word emitted into a full output register")
  `FTF_ASSERT_NXT(a_tsize_ends_run, (state_q == ST_TSIZE) && cmd_o.emit, state_q == ST_IDLE, "tag size word did not end the run")
  `FTF_ASSERT_NXT(a_first_gets_fhdr, accept && !header_sent_q, state_q == ST_FHDR, "first frame skipped the file header")

endmodule

// ===== rtl/flv_tag_framer.sv =====
// ---------------------------------------------------------------------------
// FLV tag framer
// Wraps audio or video payload words into FLV tags with a one-off file header.
// ---------------------------------------------------------------------------
// Input stream s_axis carries one payload word per request together with the
// frame fields (read on a frame's first word); tuser selects audio or video,
// tlast marks the frame's final word. Output stream m_axis carries one output
// word per transfer, tlast on the final word caused by an input request and
// tuser on the previous-tag size word. cfg_we_i writes the audio codec select.
// Each accepted request is followed by the output words it causes; one causing
// none leaves the input ready. On a frame's first word the controller emits
// the header chunks one per cycle while the output register has room. After
// acceptance the controller state register moves to the first emitting state,
// then the output register takes the first word. Reset clears the codec select,
// re-arms the file header and drops any open frame. A stalled receiver holds the
// output register and the sequence; input stays blocked until the run completes.
// ---------------------------------------------------------------------------
module flv_tag_framer #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // payload_word, payload_bytes, frame_length, time_stamp, key_frame,
  // rect_x, rect_y, rect_width, rect_height, zero pad
  input  logic [191:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_word, out_bytes, zero pad
  output logic [71:0]  m_axis_tdata,
  // end_of_tag
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  ftf_pkg::cmd_t cmd;
  ftf_pkg::sts_t sts;

  ftf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ftf_datapath #(
    .WORD_BYTES (WORD_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eot_o   (m_axis_tuser)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FLV tag framer testbench
// Drives payload requests into the framer and predicts every output word:
// the one-off file header, audio and video tag headers, pass-through payload
// and the previous-tag size. A short directed table comes first, then random
// frames under each audio codec setting, with random gaps and back-pressure.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned HDR_BYTES = 319;
  localparam logic [HDR_BYTES*8-1:0] FILE_HEADER = {
    104'h46_4c_56_01_05_00_00_00_09_00_00_00_00,
    88'h12_00_01_23_00_00_00_00_00_00_00,
    8'h02,
    96'h00_0a_6f_6e_4d_65_74_61_44_61_74_61,
    40'h08_00_00_00_0d,
    80'h00_08_64_75_72_61_74_69_6f_6e,
    72'h0,
    112'h00_0c_61_75_64_69_6f_63_6f_64_65_63_69_64,
    72'h00_40_00_00_00_00_00_00_00,
    120'h00_0d_61_75_64_69_6f_64_61_74_61_72_61_74_65,
    72'h00_40_3b_cc_cc_cc_cc_cc_cd,
    136'h00_0f_61_75_64_69_6f_73_61_6d_70_6c_65_72_61_74_65,
    72'h00_40_e5_88_80_00_00_00_00,
    136'h00_0f_61_75_64_69_6f_73_61_6d_70_6c_65_73_69_7a_65,
    72'h00_40_30_00_00_00_00_00_00,
    64'h00_06_73_74_65_72_65_6f,
    16'h01_01,
    112'h00_0c_76_69_64_65_6f_63_6f_64_65_63_69_64,
    72'h00_40_20_00_00_00_00_00_00,
    56'h00_05_77_69_64_74_68,
    72'h00_40_84_00_00_00_00_00_00,
    64'h00_06_68_65_69_67_68_74,
    72'h00_40_7e_00_00_00_00_00_00,
    88'h00_09_66_72_61_6d_65_72_61_74_65,
    72'h0,
    120'h00_0d_76_69_64_65_6f_64_61_74_61_72_61_74_65,
    72'h0,
    72'h00_07_65_6e_63_6f_64_65_72,
    112'h02_00_0b_4c_61_76_66_35_32_2e_38_37_2e_31,
    80'h00_08_66_69_6c_65_73_69_7a_65,
    72'h0,
    24'h00_00_09,
    32'h00_00_01_2e
  };

  localparam logic       MODE_AUDIO    = ftf_pkg::MODE_AUDIO;
  localparam logic       MODE_VIDEO    = 1'b0;
  localparam logic [1:0] CODEC_MP3_16K = ftf_pkg::CODEC_MP3_16K;
  localparam logic [1:0] CODEC_MP3     = ftf_pkg::CODEC_MP3;
  localparam logic [1:0] CODEC_SPEEX   = 2'd0;
  localparam logic [1:0] CODEC_SPARE   = 2'd3;
  localparam logic [7:0] PHASE_CODECS = {CODEC_SPEEX, CODEC_SPARE, CODEC_MP3, CODEC_MP3_16K};

  localparam logic [7:0]  TYPE_AUDIO_BYTE = 8'h08;
  localparam logic [7:0]  TYPE_VIDEO_BYTE = 8'h09;
  localparam logic [7:0]  KEY_BYTE        = 8'h18;
  localparam logic [7:0]  INTER_BYTE      = 8'h28;
  localparam logic [7:0]  SPEEX_BYTE      = 8'hbe;
  localparam logic [7:0]  MP3_16K_BYTE    = 8'hfe;
  localparam logic [7:0]  MP3_BYTE        = 8'h2f;
  localparam logic [23:0] LEN_CAP         = 24'd16777206;
  localparam logic [24:0] TAG_HDR_LEN     = 25'd11;

  localparam int unsigned N_DIR          = 14;
  localparam int unsigned PHASE_REQS     = 112;
  localparam int unsigned CALM_FROM      = 410;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TIMEOUT_CYCLES = 1_200_000;

  typedef struct packed {
    logic        mode;
    logic [63:0] pword;
    logic [3:0]  pbytes;
    logic        last;
    logic [23:0] flen;
    logic [31:0] ts;
    logic        key;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rw;
    logic [15:0] rh;
  } payload_req_t;

  typedef struct packed {
    payload_req_t req;
    logic         typed;
    logic [24:0]  tsize;
  } dir_row_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        run_end;
    logic        tag_end;
  } out_word_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_wdata_i   = 2'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  // predictor state
  logic        hdr_done   = 1'b0;
  logic        frame_open = 1'b0;
  logic [24:0] held_size  = '0;
  logic [1:0]  codec_sel  = CODEC_SPEEX;

  out_word_t   tag_words_q [$];
  int unsigned sent        = 0;
  int unsigned received    = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned stall_left  = 0;
  int unsigned phase_start = 0;
  logic        calm        = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    '{'{MODE_AUDIO, 64'h0, 4'd0, 1'b1, 24'd0, 32'h0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      1'b1, 25'd12},
    '{'{MODE_VIDEO, {64{1'b1}}, 4'd8, 1'b0, 24'hffffff, 32'hffffffff, 1'b1,
        16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b0, 25'd0},
    '{'{MODE_AUDIO, 64'h0123456789abcdef, 4'd15, 1'b0, 24'h0, 32'h0, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, 25'd0},
    '{'{MODE_VIDEO, 64'hdeadbeefcafef00d, 4'd0, 1'b0, 24'h123456, 32'h13572468, 1'b1,
        16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1'b0, 25'd0},
    '{'{MODE_VIDEO, 64'h8000000000000001, 4'd3, 1'b1, 24'd0, 32'h0, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd16777226},
    '{'{MODE_VIDEO, 64'h0, 4'd8, 1'b1, 24'd16777206, 32'h0, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd16777226},
    '{'{MODE_AUDIO, 64'h5555555555555555, 4'd1, 1'b0, 24'd16777207, 32'h5a5a5a5a, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, 25'd0},
    '{'{MODE_AUDIO, 64'h0, 4'd0, 1'b1, 24'd0, 32'h0, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd16777218},
    '{'{MODE_AUDIO, 64'haaaaaaaaaaaaaaaa, 4'd5, 1'b1, 24'd5, 32'h12345678, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd17},
    '{'{MODE_VIDEO, 64'h0, 4'd0, 1'b0, 24'd20, 32'h80000001, 1'b1,
        16'h1234, 16'h8000, 16'h0001, 16'h7fff}, 1'b0, 25'd0},
    '{'{MODE_AUDIO, 64'hfedcba9876543210, 4'd8, 1'b0, 24'd999, 32'hffff0000, 1'b0,
        16'hffff, 16'h0, 16'hffff, 16'h0}, 1'b0, 25'd0},
    '{'{MODE_VIDEO, 64'h0f0f0f0f0f0f0f0f, 4'd4, 1'b1, 24'd0, 32'h0, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd40},
    '{'{MODE_AUDIO, {64{1'b1}}, 4'd9, 1'b1, 24'd0, 32'h00ffffff, 1'b0,
        16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 25'd12},
    '{'{MODE_VIDEO, 64'h00ff00ff00ff00ff, 4'd12, 1'b1, 24'd100, 32'h7f000080, 1'b0,
        16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0}, 1'b1, 25'd120}
  };

  flv_tag_framer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_chunks(input logic [7:0] hdr_q [$]);
    out_word_t o;
    int        pos;
    int        span;
    pos = 0;
    while (pos < hdr_q.size()) begin
      span = (hdr_q.size() - pos > 8) ? 8 : hdr_q.size() - pos;
      o = '0;
      for (int i = 0; i < span; i++) begin
        o.word[63-8*i -: 8] = hdr_q[pos+i];
      end
      o.nbytes = 4'(span);
      tag_words_q.push_back(o);
      pos += span;
    end
  endtask

  task automatic predict_tag_words(input payload_req_t r);
    logic [7:0]  fhdr_q [$];
    logic [7:0]  thdr_q [$];
    logic [23:0] flen;
    logic [23:0] dlen;
    logic [3:0]  nb;
    out_word_t   o;
    int          first;
    first = tag_words_q.size();
    nb = (r.pbytes > 4'd8) ? 4'd8 : r.pbytes;
    if (!frame_open) begin
      flen = (r.flen > LEN_CAP) ? LEN_CAP : r.flen;
      if (!hdr_done) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          fhdr_q.push_back(FILE_HEADER[8*(HDR_BYTES-1-i) +: 8]);
        end
        push_chunks(fhdr_q);
        hdr_done = 1'b1;
      end
      dlen = flen + ((r.mode == MODE_AUDIO) ? 24'd1 : 24'd9);
      thdr_q = '{(r.mode == MODE_AUDIO) ? TYPE_AUDIO_BYTE : TYPE_VIDEO_BYTE,
                 dlen[23:16], dlen[15:8], dlen[7:0],
                 r.ts[23:16], r.ts[15:8], r.ts[7:0], r.ts[31:24], 8'h0, 8'h0, 8'h0};
      if (r.mode == MODE_AUDIO) begin
        case (codec_sel)
          CODEC_MP3_16K: thdr_q.push_back(MP3_16K_BYTE);
          CODEC_MP3:     thdr_q.push_back(MP3_BYTE);
          default:       thdr_q.push_back(SPEEX_BYTE);
        endcase
      end else begin
        thdr_q.push_back(r.key ? KEY_BYTE : INTER_BYTE);
        thdr_q.push_back(r.rx[15:8]);
        thdr_q.push_back(r.rx[7:0]);
        thdr_q.push_back(r.ry[15:8]);
        thdr_q.push_back(r.ry[7:0]);
        thdr_q.push_back(r.rw[15:8]);
        thdr_q.push_back(r.rw[7:0]);
        thdr_q.push_back(r.rh[15:8]);
        thdr_q.push_back(r.rh[7:0]);
      end
      push_chunks(thdr_q);
      held_size = TAG_HDR_LEN + {1'b0, dlen};
    end
    if (nb != 4'd0) begin
      o = '{r.pword, nb, 1'b0, 1'b0};
      tag_words_q.push_back(o);
    end
    if (r.last) begin
      o = '{{7'd0, held_size, 32'd0}, 4'd4, 1'b0, 1'b1};
      tag_words_q.push_back(o);
      frame_open = 1'b0;
    end else begin
      frame_open = 1'b1;
    end
    if (tag_words_q.size() > first) begin
      tag_words_q[tag_words_q.size()-1].run_end = 1'b1;
    end
  endtask

  task automatic send_request(input payload_req_t r, input logic typed, input logic [24:0] tsize);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.mode;
    s_axis_tlast  <= r.last;
    s_axis_tdata  <= {3'd0, r.rh, r.rw, r.ry, r.rx, r.key, r.ts, r.flen, r.pbytes, r.pword};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tag_words(r);
    if (typed) begin
      tag_words_q[tag_words_q.size()-1].word = {7'd0, tsize, 32'd0};
    end
    sent++;
    if (sent >= CALM_FROM) begin
      calm = 1'b1;
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_frame();
    payload_req_t r;
    int           words;
    words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
    for (int w = 0; w < words; w++) begin
      r.mode  = 1'($urandom);
      r.pword = {$urandom, $urandom};
      r.last  = (w == words - 1);
      case ($urandom_range(0, 11))
        0:       r.pbytes = 4'($urandom_range(0, 15));
        1, 2:    r.pbytes = 4'($urandom_range(1, 8));
        default: r.pbytes = r.last ? 4'($urandom_range(1, 8)) : 4'd8;
      endcase
      case ($urandom_range(0, 15))
        0, 1:    r.flen = 24'($urandom);
        2:       r.flen = 24'($urandom_range(16777200, 16777215));
        default: r.flen = 24'($urandom_range(0, 2000));
      endcase
      r.ts  = $urandom;
      r.key = 1'($urandom);
      r.rx  = 16'($urandom);
      r.ry  = 16'($urandom);
      r.rw  = 16'($urandom);
      r.rh  = 16'($urandom);
      send_request(r, 1'b0, 25'd0);
    end
  endtask

  task automatic write_codec(input logic [1:0] value);
    s_axis_tvalid <= 1'b0;
    while (tag_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    codec_sel = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_tag_word();
    out_word_t want;
    if (tag_words_q.size() == 0) begin
      if (errors < 10) begin
        $display("unexpected output word %h bytes %0d last %b eot %b",
                 m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser);
      end
      errors++;
    end else begin
      want = tag_words_q.pop_front();
      if (want.word !== m_axis_tdata[63:0] || want.nbytes !== m_axis_tdata[67:64] ||
          want.run_end !== m_axis_tlast || want.tag_end !== m_axis_tuser) begin
        if (errors < 10) begin
          $display("output %0d: expected word %h bytes %0d last %b eot %b", received,
                   want.word, want.nbytes, want.run_end, want.tag_end);
          $display("output %0d:      got word %h bytes %0d last %b eot %b", received,
                   m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser);
        end
        errors++;
      end
    end
    received++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_tag_word();
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, tag_words_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < N_DIR; i++) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].tsize);
    end
    for (int p = 0; p < 4; p++) begin
      write_codec(PHASE_CODECS[2*p +: 2]);
      phase_start = sent;
      while (sent - phase_start < PHASE_REQS) begin
        send_random_frame();
      end
    end
    s_axis_tvalid <= 1'b0;
    while (tag_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("framed %0d payload requests into %0d output words under all four codec codes",
             sent, received);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
